// ===== rtl/core/smrs_pkg.sv =====
// Shared types and constants for the serial mouse report shifter.
// Used by smrs_axis_accum and serial_mouse_report_shifter_core; no dependencies.
`default_nettype none
package smrs_pkg;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      CMD_MOTION = 2'd0,
      CMD_STROBE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Field widths.
   localparam int unsigned DELTA_W  = 8;
   localparam int unsigned MAG_W    = 7;
   localparam int unsigned BTN_W    = 2;
   localparam int unsigned SENS_W   = 2;
   localparam int unsigned REPORT_W = 32;

   // Highest sensitivity that is ever reached before wrapping to zero.
   localparam logic [SENS_W-1:0] SENS_TOP = 2'd2;

   // Control from the core to one axis accumulator.
   typedef struct packed {
      logic add_en;  // add the scaled delta
      logic clear;   // clear after a report latch
   } axis_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/core/smrs_axis_accum.sv =====
// One 8-bit wrapping motion accumulator with scaling and sign/magnitude output.
// Depends on smrs_pkg.
`default_nettype none
module smrs_axis_accum (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire smrs_pkg::axis_ctrl_type              ctrl,
   input  wire logic signed [smrs_pkg::DELTA_W-1:0]  delta,
   input  wire logic [1:0]                           shift_amt,
   output logic                                      sign,
   output logic [smrs_pkg::MAG_W-1:0]                magnitude
);

   logic [smrs_pkg::DELTA_W-1:0] accum_ff;
   logic [smrs_pkg::DELTA_W-1:0] accum_in;
   logic [smrs_pkg::DELTA_W-1:0] delta_mag;
   logic [smrs_pkg::DELTA_W-1:0] scaled;
   logic [smrs_pkg::DELTA_W-1:0] accum_abs;

   // Magnitude of the delta; the most negative value wraps to 128, which is right here.
   assign delta_mag = delta[smrs_pkg::DELTA_W-1] ? (smrs_pkg::DELTA_W'(0) - delta) : delta;
   // Shifting the magnitude truncates toward zero for either sign.
   assign scaled    = delta_mag >> shift_amt;

   // Next accumulator value.
   always_comb begin
      accum_in = accum_ff;
      if (ctrl.clear) begin
         accum_in = '0;
      end else if (ctrl.add_en) begin
         if (delta[smrs_pkg::DELTA_W-1]) begin
            accum_in = accum_ff - scaled;
         end else begin
            accum_in = accum_ff + scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else begin
         accum_ff <= accum_in;
      end
   end

   // Sign and 7-bit magnitude for the report; -128 gives sign set, magnitude zero.
   assign sign      = accum_ff[smrs_pkg::DELTA_W-1];
   assign accum_abs = sign ? (smrs_pkg::DELTA_W'(0) - accum_ff) : accum_ff;
   assign magnitude = accum_abs[smrs_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/serial_mouse_report_shifter_core.sv =====
// Top level of the serial mouse report shifter: request register, state update, result register.
// Depends on smrs_pkg and smrs_axis_accum.
//
//   channel | direction | contents
//   req_    | in        | tuser = command, tdata = deltas, buttons, strobe level
//   rsp_    | out       | tdata = one report bit (data reads only)
//
// A request is registered on acceptance and processed from the request register; a read's bit
// is then registered in the result register. One request can be accepted every cycle while the
// request register advances, which it does unless it holds a read while the result register is
// full and stalled; reset is synchronous and clears the accumulators, report and all valid bits.
`default_nettype none
module serial_mouse_report_shifter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // [7:0] delta_x, [15:8] delta_y, [17:16] button_bits, [18] strobe_level, [23:19] zero
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] data_bit, [7:1] zero
);

   // Request register.
   logic                                   stage_valid_ff;
   smrs_pkg::cmd_type                      stage_cmd_ff;
   logic signed [smrs_pkg::DELTA_W-1:0]    stage_dx_ff;
   logic signed [smrs_pkg::DELTA_W-1:0]    stage_dy_ff;
   logic [smrs_pkg::BTN_W-1:0]             stage_btn_ff;
   logic                                   stage_strobe_ff;

   // Block state.
   logic                                   strobe_held_ff;
   logic                                   strobe_held_in;
   logic [smrs_pkg::BTN_W-1:0]             buttons_ff;
   logic [smrs_pkg::BTN_W-1:0]             buttons_in;
   logic [smrs_pkg::SENS_W-1:0]            sens_ff;
   logic [smrs_pkg::SENS_W-1:0]            sens_in;
   logic [smrs_pkg::REPORT_W-1:0]          report_ff;
   logic [smrs_pkg::REPORT_W-1:0]          report_in;

   // Result register.
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic                                   rsp_bit_ff;
   logic                                   rsp_bit_in;

   logic                                   out_free;
   logic                                   stage_fire;
   logic                                   stage_is_read;
   logic                                   latch;
   logic [1:0]                             shift_amt;
   smrs_pkg::axis_ctrl_type                axis_ctrl;
   logic                                   x_sign;
   logic                                   y_sign;
   logic [smrs_pkg::MAG_W-1:0]             x_mag;
   logic [smrs_pkg::MAG_W-1:0]             y_mag;

   // Handshake: a read needs room in the result register, other commands never stall.
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign stage_is_read = (stage_cmd_ff == smrs_pkg::CMD_READ);
   assign stage_fire    = stage_valid_ff && (!stage_is_read || out_free);
   assign req_tready    = !stage_valid_ff || stage_fire;

   // Capture an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         stage_cmd_ff    <= smrs_pkg::cmd_type'(req_tuser);
         stage_dx_ff     <= req_tdata[7:0];
         stage_dy_ff     <= req_tdata[15:8];
         stage_btn_ff    <= req_tdata[17:16];
         stage_strobe_ff <= req_tdata[18];
      end
   end

   // Scale shift is two minus sensitivity, or none for the unreachable level three.
   assign shift_amt = (sens_ff > smrs_pkg::SENS_TOP) ? 2'd0 : (smrs_pkg::SENS_TOP - sens_ff);

   // A falling strobe latches the report.
   assign latch = stage_fire && (stage_cmd_ff == smrs_pkg::CMD_STROBE)
                  && strobe_held_ff && !stage_strobe_ff;

   assign axis_ctrl.add_en = stage_fire && (stage_cmd_ff == smrs_pkg::CMD_MOTION);
   assign axis_ctrl.clear  = latch;

   smrs_axis_accum u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (axis_ctrl),
      .delta     (stage_dx_ff),
      .shift_amt (shift_amt),
      .sign      (x_sign),
      .magnitude (x_mag)
   );

   smrs_axis_accum u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (axis_ctrl),
      .delta     (stage_dy_ff),
      .shift_amt (shift_amt),
      .sign      (y_sign),
      .magnitude (y_mag)
   );

   // Command processing; the report shifts out MSB first with zeros filling behind.
   always_comb begin
      strobe_held_in = strobe_held_ff;
      buttons_in     = buttons_ff;
      sens_in        = sens_ff;
      report_in      = report_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_bit_in     = rsp_bit_ff;
      if (stage_fire) begin
         case (stage_cmd_ff)
            smrs_pkg::CMD_MOTION: begin
               buttons_in = stage_btn_ff;
            end
            smrs_pkg::CMD_STROBE: begin
               strobe_held_in = stage_strobe_ff;
               if (latch) begin
                  report_in = {8'd0, buttons_ff, sens_ff, 3'd0, 1'b1,
                               y_sign, y_mag, x_sign, x_mag};
               end
            end
            smrs_pkg::CMD_READ: begin
               if (strobe_held_ff) begin
                  sens_in = (sens_ff >= smrs_pkg::SENS_TOP)
                            ? (sens_ff - smrs_pkg::SENS_TOP) : (sens_ff + 2'd1);
               end
               rsp_valid_in = 1'b1;
               rsp_bit_in   = report_ff[smrs_pkg::REPORT_W-1];
               report_in    = {report_ff[smrs_pkg::REPORT_W-2:0], 1'b0};
            end
            default: begin
            end
         endcase
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_held_ff <= 1'b0;
         buttons_ff     <= '0;
         sens_ff        <= '0;
         report_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         strobe_held_ff <= strobe_held_in;
         buttons_ff     <= buttons_in;
         sens_ff        <= sens_in;
         report_ff      <= report_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bit_ff};

endmodule
`default_nettype wire
